[src/bblur_pkg.sv]
// ----------------------------------------------------------------------------
// bblur_pkg
// Shared types and constants of the 3x3 box blur: geometry limits, pixel
// layout, operation and register codes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package bblur_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    // Column index into a line memory.
    localparam int COL_W     = $clog2(MAX_WIDTH);
    // Output row index.
    localparam int OUT_ROW_W = $clog2(MAX_HEIGHT);
    // Input row counts on up to the height plus one while draining.
    localparam int IN_ROW_W  = $clog2(MAX_HEIGHT + 2);
    // Width of the geometry registers.
    localparam int DIM_W     = 11;

    localparam logic [DIM_W-1:0] WIDTH_MAX_V  = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] HEIGHT_MAX_V = DIM_W'(MAX_HEIGHT);

    // Operation carried in tuser.
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // Configuration register indexes.
    localparam int  CFG_IDX_W        = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    // Steps of the restoring divider: the quotient never exceeds 255.
    localparam int DIV_STEPS = 8;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_ROWS,
        ST_TOTAL,
        ST_DIV,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic accept;
        logic shift;
        logic rows;
        logic total;
        logic div_step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic skip;
        logic emit;
        logic div_done;
        logic out_free;
    } t_status;

endpackage

[src/box_blur_three_by_three.sv]
// ----------------------------------------------------------------------------
// box_blur_three_by_three
// Streaming 3x3 box blur for 24-bit RGB pixels in raster order.
// ----------------------------------------------------------------------------
// Each pixel's result is the rounded-half-up mean of every channel over the
// part of its 3x3 neighborhood that lies inside the image (9, 6, 4 or fewer
// pixels). Results lag the input by image_width+1 items, so after the last
// pixel of a frame send drain items (tuser high) until the result with tlast
// arrives; drain items before the end of the frame are dropped. An item that
// yields a result goes through transfer with line read, line update, row sums,
// total, an 8-step restoring divider with one lane per channel, and the load
// into the output register, which waits for a free output. Items without a
// result go idle after the line update. The output register lets the next item
// enter while a result waits. The two line memories are not cleared, so set
// image_width and image_height only between frames, while the block is idle.
module box_blur_three_by_three (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write port
    input  logic                              i_cfg_we,
    input  logic [bblur_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bblur_pkg::DIM_W-1:0]       i_cfg_wdata,
    // Input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [23:0]                       s_axis_tdata,  // red_in, green_in, blue_in
    input  logic                              s_axis_tuser,  // operation
    // Output stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [23:0]                       m_axis_tdata,  // red_out, green_out, blue_out
    output logic                              m_axis_tlast   // frame_end
);

    bblur_pkg::t_cmd    cmd;
    bblur_pkg::t_status status;
    bblur_pkg::t_pixel  in_pixel;
    bblur_pkg::t_pixel  out_pixel;

    assign in_pixel.red   = s_axis_tdata[7:0];
    assign in_pixel.green = s_axis_tdata[15:8];
    assign in_pixel.blue  = s_axis_tdata[23:16];

    bblur_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    bblur_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in_op     (s_axis_tuser),
        .i_in_pixel  (in_pixel),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_pixel (out_pixel),
        .o_out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {out_pixel.blue, out_pixel.green, out_pixel.red};

    // A new result never overwrites one that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result loaded over a pending result");

    // While the block takes input, no earlier item is still being worked on.
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !(cmd.shift || cmd.rows || cmd.total || cmd.div_step
                            || cmd.load_out))
        else $error("input taken while an item is in flight");

    // The divider runs right after its operands are loaded.
    a_div_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.total |=> cmd.div_step)
        else $error("divider did not start after load");

    // An item that yields no result frees the input in the next cycle.
    a_no_emit_return: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.shift && !status.emit) |=> s_axis_tready)
        else $error("block stalled after an item without result");

endmodule

[src/bblur_ram.sv]
// ----------------------------------------------------------------------------
// bblur_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module bblur_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [DATA_W-1:0]                           i_wdata,
    input  logic                                        i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [DATA_W-1:0]                           o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/bblur_ctrl.sv]
// ----------------------------------------------------------------------------
// bblur_ctrl
// Controller of the box blur: steps one item through line update, row sums,
// total, division and output load.
// ----------------------------------------------------------------------------
module bblur_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  bblur_pkg::t_status  i_status,
    output bblur_pkg::t_cmd     o_cmd
);

    bblur_pkg::t_state r_state;
    bblur_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bblur_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            bblur_pkg::ST_IDLE: begin
                if (i_in_valid && !i_status.skip) begin
                    n_state = bblur_pkg::ST_SHIFT;
                end
            end
            bblur_pkg::ST_SHIFT: begin
                n_state = i_status.emit ? bblur_pkg::ST_ROWS : bblur_pkg::ST_IDLE;
            end
            bblur_pkg::ST_ROWS: begin
                n_state = bblur_pkg::ST_TOTAL;
            end
            bblur_pkg::ST_TOTAL: begin
                n_state = bblur_pkg::ST_DIV;
            end
            bblur_pkg::ST_DIV: begin
                if (i_status.div_done) begin
                    n_state = bblur_pkg::ST_OUT;
                end
            end
            bblur_pkg::ST_OUT: begin
                if (i_status.out_free) begin
                    n_state = bblur_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bblur_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            bblur_pkg::ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            bblur_pkg::ST_SHIFT: begin
                o_cmd.shift = 1'b1;
            end
            bblur_pkg::ST_ROWS: begin
                o_cmd.rows = 1'b1;
            end
            bblur_pkg::ST_TOTAL: begin
                o_cmd.total = 1'b1;
            end
            bblur_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            bblur_pkg::ST_OUT: begin
                o_cmd.load_out = i_status.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

[src/bblur_datapath.sv]
// ----------------------------------------------------------------------------
// bblur_datapath
// Datapath of the box blur: geometry registers, position counters, two line
// memories, the 3x3 window, row and total sums, a three-lane restoring
// divider and the output register.
// ----------------------------------------------------------------------------
module bblur_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [bblur_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bblur_pkg::DIM_W-1:0]         i_cfg_wdata,
    input  bblur_pkg::t_cmd                     i_cmd,
    output bblur_pkg::t_status                  o_status,
    input  logic                                i_in_op,
    input  bblur_pkg::t_pixel                   i_in_pixel,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output bblur_pkg::t_pixel                   o_out_pixel,
    output logic                                o_out_last
);

    localparam int DIM_W = bblur_pkg::DIM_W;

    // Geometry registers and their clamped values.
    logic [DIM_W-1:0] r_image_width;
    logic [DIM_W-1:0] r_image_height;
    logic [DIM_W-1:0] w_eff;
    logic [DIM_W-1:0] h_eff;

    // Position counters.
    logic [bblur_pkg::COL_W-1:0]     r_in_column;
    logic [bblur_pkg::IN_ROW_W-1:0]  r_in_row;
    logic [bblur_pkg::COL_W-1:0]     r_out_column;
    logic [bblur_pkg::OUT_ROW_W-1:0] r_out_row;

    // Item captured at transfer.
    logic              r_is_pixel;
    bblur_pkg::t_pixel r_pixel;

    // Line memories.
    bblur_pkg::t_pixel upper_rd;
    bblur_pkg::t_pixel middle_rd;
    bblur_pkg::t_pixel bot_px;

    bblur_pkg::t_pixel r_win [3][3];

    // Neighborhood masks of the result in progress.
    logic r_top_en;
    logic r_bot_en;
    logic r_left_en;
    logic r_right_en;
    logic r_last;
    logic row_en [3];
    logic col_en [3];

    logic [9:0]  r_row_sum [3][3];
    logic [9:0]  row_sum_c [3][3];
    logic [3:0]  r_n;
    logic [1:0]  rows_cnt;
    logic [1:0]  cols_cnt;
    logic [3:0]  n_c;

    // Divider lanes: red, green, blue.
    logic [4:0]  r_rem [3];
    logic [7:0]  r_q [3];
    logic [4:0]  r_divisor;
    logic [bblur_pkg::DIV_CNT_W-1:0] r_div_cnt;
    logic [4:0]  rem_step [3];
    logic        qbit_step [3];
    logic [12:0] dividend [3];

    logic              r_out_valid;
    bblur_pkg::t_pixel r_out_pixel;
    logic              r_out_last;

    logic in_row_live;
    logic emit;
    logic in_col_wrap;
    logic out_col_wrap;
    logic out_row_last;
    logic last_now;

    function automatic logic [7:0] get_chan(input bblur_pkg::t_pixel p, input logic [1:0] k);
        logic [7:0] v;
        case (k)
            2'd0:    v = p.red;
            2'd1:    v = p.green;
            default: v = p.blue;
        endcase
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Geometry
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= bblur_pkg::WIDTH_MAX_V;
            r_image_height <= bblur_pkg::HEIGHT_MAX_V;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bblur_pkg::CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_wdata;
                bblur_pkg::CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_image_width == '0) begin
            w_eff = DIM_W'(1);
        end else if (r_image_width > bblur_pkg::WIDTH_MAX_V) begin
            w_eff = bblur_pkg::WIDTH_MAX_V;
        end else begin
            w_eff = r_image_width;
        end
        if (r_image_height == '0) begin
            h_eff = DIM_W'(1);
        end else if (r_image_height > bblur_pkg::HEIGHT_MAX_V) begin
            h_eff = bblur_pkg::HEIGHT_MAX_V;
        end else begin
            h_eff = r_image_height;
        end
    end

    // ------------------------------------------------------------------
    // Position decode
    // ------------------------------------------------------------------
    always_comb begin
        in_row_live  = DIM_W'(r_in_row) < h_eff;
        emit         = (r_in_row >= bblur_pkg::IN_ROW_W'(2))
                    || ((r_in_row == bblur_pkg::IN_ROW_W'(1)) && (r_in_column != '0));
        in_col_wrap  = (DIM_W'(r_in_column) + DIM_W'(1)) >= w_eff;
        out_col_wrap = (DIM_W'(r_out_column) + DIM_W'(1)) >= w_eff;
        out_row_last = (DIM_W'(r_out_row) + DIM_W'(1)) >= h_eff;
        last_now     = out_row_last && out_col_wrap;
    end

    // A drain item is dropped until the frame's last pixel has come in.
    assign o_status.skip     = (i_in_op == bblur_pkg::OP_DRAIN) && in_row_live;
    assign o_status.emit     = emit;
    assign o_status.div_done = (r_div_cnt == bblur_pkg::DIV_CNT_W'(bblur_pkg::DIV_STEPS - 1));
    assign o_status.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_is_pixel <= (i_in_op == bblur_pkg::OP_PIXEL) && in_row_live;
            r_pixel    <= i_in_pixel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_column  <= '0;
            r_in_row     <= '0;
            r_out_column <= '0;
            r_out_row    <= '0;
        end else if (i_cmd.shift) begin
            // The frame's last result returns every counter to the start.
            if (emit && last_now) begin
                r_in_column  <= '0;
                r_in_row     <= '0;
                r_out_column <= '0;
                r_out_row    <= '0;
            end else begin
                if (in_col_wrap) begin
                    r_in_column <= '0;
                    if (DIM_W'(r_in_row) < h_eff + DIM_W'(1)) begin
                        r_in_row <= r_in_row + bblur_pkg::IN_ROW_W'(1);
                    end
                end else begin
                    r_in_column <= r_in_column + bblur_pkg::COL_W'(1);
                end
                if (emit) begin
                    if (out_col_wrap) begin
                        r_out_column <= '0;
                        r_out_row    <= r_out_row + bblur_pkg::OUT_ROW_W'(1);
                    end else begin
                        r_out_column <= r_out_column + bblur_pkg::COL_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.shift) begin
            r_top_en   <= r_out_row != '0;
            r_bot_en   <= !out_row_last;
            r_left_en  <= r_out_column != '0;
            r_right_en <= !out_col_wrap;
            r_last     <= last_now;
        end
    end

    // ------------------------------------------------------------------
    // Line memories: read at transfer, written back in the shift cycle
    // ------------------------------------------------------------------
    assign bot_px = r_is_pixel ? r_pixel : '0;

    bblur_ram #(
        .DATA_W ($bits(bblur_pkg::t_pixel)),
        .DEPTH  (bblur_pkg::MAX_WIDTH)
    ) u_upper_line (
        .i_clk   (i_clk),
        .i_we    (i_cmd.shift && r_is_pixel),
        .i_waddr (r_in_column),
        .i_wdata (middle_rd),
        .i_re    (i_cmd.accept),
        .i_raddr (r_in_column),
        .o_rdata (upper_rd)
    );

    bblur_ram #(
        .DATA_W ($bits(bblur_pkg::t_pixel)),
        .DEPTH  (bblur_pkg::MAX_WIDTH)
    ) u_middle_line (
        .i_clk   (i_clk),
        .i_we    (i_cmd.shift && r_is_pixel),
        .i_waddr (r_in_column),
        .i_wdata (r_pixel),
        .i_re    (i_cmd.accept),
        .i_raddr (r_in_column),
        .o_rdata (middle_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_win[r][c] <= '0;
                end
            end
        end else if (i_cmd.shift) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r][0] <= r_win[r][1];
                r_win[r][1] <= r_win[r][2];
            end
            r_win[0][2] <= upper_rd;
            r_win[1][2] <= middle_rd;
            r_win[2][2] <= bot_px;
        end
    end

    // ------------------------------------------------------------------
    // Masked row sums and pixel count
    // ------------------------------------------------------------------
    assign row_en[0] = r_top_en;
    assign row_en[1] = 1'b1;
    assign row_en[2] = r_bot_en;
    assign col_en[0] = r_left_en;
    assign col_en[1] = 1'b1;
    assign col_en[2] = r_right_en;

    always_comb begin
        logic [9:0] acc;
        for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
                acc = '0;
                for (int c = 0; c < 3; c++) begin
                    if (col_en[c]) begin
                        acc = acc + {2'b00, get_chan(r_win[r][c], 2'(k))};
                    end
                end
                row_sum_c[r][k] = row_en[r] ? acc : '0;
            end
        end
    end

    assign rows_cnt = 2'd1 + {1'b0, r_top_en} + {1'b0, r_bot_en};
    assign cols_cnt = 2'd1 + {1'b0, r_left_en} + {1'b0, r_right_en};
    assign n_c      = {2'b00, rows_cnt} * {2'b00, cols_cnt};

    always_ff @(posedge i_clk) begin
        if (i_cmd.rows) begin
            r_row_sum <= row_sum_c;
            r_n       <= n_c;
        end
    end

    // ------------------------------------------------------------------
    // Rounded mean: (2*sum + n) / (2*n), one quotient bit per cycle
    // ------------------------------------------------------------------
    always_comb begin
        logic [5:0] trial;
        for (int k = 0; k < 3; k++) begin
            dividend[k] = {({2'b00, r_row_sum[0][k]} + {2'b00, r_row_sum[1][k]}
                          + {2'b00, r_row_sum[2][k]}), 1'b0} + {9'b0, r_n};
            trial        = {r_rem[k], r_q[k][7]};
            qbit_step[k] = trial >= {1'b0, r_divisor};
            rem_step[k]  = qbit_step[k] ? 5'(trial - {1'b0, r_divisor}) : trial[4:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.total) begin
            r_divisor <= {r_n, 1'b0};
            for (int k = 0; k < 3; k++) begin
                // The quotient fits eight bits, so the top five bits start
                // below the divisor.
                r_rem[k] <= dividend[k][12:8];
                r_q[k]   <= dividend[k][7:0];
            end
        end else if (i_cmd.div_step) begin
            for (int k = 0; k < 3; k++) begin
                r_rem[k] <= rem_step[k];
                r_q[k]   <= {r_q[k][6:0], qbit_step[k]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt <= '0;
        end else if (i_cmd.total) begin
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_div_cnt <= r_div_cnt + bblur_pkg::DIV_CNT_W'(1);
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_pixel.red   <= r_q[0];
            r_out_pixel.green <= r_q[1];
            r_out_pixel.blue  <= r_q[2];
            r_out_last        <= r_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_pixel = r_out_pixel;
    assign o_out_last  = r_out_last;

endmodule
